@@ src/delta_von_neumann_debiaser_top_macros.svh @@
// ----------------------------------------------------------------------------
// delta von neumann debiaser assertion macros
// shared property templates for the port checker
// ----------------------------------------------------------------------------
`ifndef DELTA_VON_NEUMANN_DEBIASER_TOP_MACROS_SVH
`define DELTA_VON_NEUMANN_DEBIASER_TOP_MACROS_SVH

// antecedent in one cycle implies consequent in the next, outside reset
`define DVND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// checked through reset: a cycle with reset asserted implies consequent next
`define DVND_ASSERT_RESET(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error(msg);

`endif

@@ src/dvnd_pkg.sv @@
// ----------------------------------------------------------------------------
// dvnd_pkg
// shared constants, beat types and helpers of the debiaser
// ----------------------------------------------------------------------------
package dvnd_pkg;

    localparam int NUM_CHANNELS_DEF = 2;
    localparam int MAX_PLANES_DEF   = 16;
    localparam int SAMPLE_W         = 16;
    localparam int CFG_W            = 5;
    localparam int BYTE_W           = 8;
    localparam int ACC_W            = 24;   // 8-bit held byte plus 16 new bits
    localparam int OUT_DEPTH        = 4;

    localparam logic [CFG_W-1:0] PLANES_RESET = 5'd16;

    typedef struct packed {
        logic                       channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first_of_read;
    } t_item;

    typedef struct packed {
        logic              out_channel;
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_beat;

    // up to two beats written into the output queue in one cycle
    typedef struct packed {
        logic  vld0;
        logic  vld1;
        t_beat beat0;
        t_beat beat1;
    } t_push;

    function automatic logic [4:0] popcnt16(input logic [15:0] v);
        logic [2:0] nib [4];
        for (int q = 0; q < 4; q++) begin
            nib[q] = 3'(v[4*q]) + 3'(v[4*q+1]) + 3'(v[4*q+2]) + 3'(v[4*q+3]);
        end
        return (5'(nib[0]) + 5'(nib[1])) + (5'(nib[2]) + 5'(nib[3]));
    endfunction

endpackage

@@ src/dvnd_if.sv @@
// ----------------------------------------------------------------------------
// dvnd_if
// valid/ready channels for samples in and debiased bytes out
// ----------------------------------------------------------------------------
interface dvnd_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 channel;
    logic signed [dvnd_pkg::SAMPLE_W-1:0] sample;
    logic                                 first_of_read;

    modport source (output valid, channel, sample, first_of_read, input ready);
    modport sink   (input valid, channel, sample, first_of_read, output ready);
endinterface

interface dvnd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        out_channel;
    logic [dvnd_pkg::BYTE_W-1:0] out_byte;
    logic                        last;

    modport source (output valid, out_channel, out_byte, last, input ready);
    modport sink   (input valid, out_channel, out_byte, last, output ready);
endinterface

@@ src/delta_von_neumann_debiaser_top.sv @@
// ----------------------------------------------------------------------------
// delta_von_neumann_debiaser_top
// von neumann extractor run on each bit plane of per-channel sample deltas
// ----------------------------------------------------------------------------
// Samples come in on i_in, one beat each, tagged with their channel. The
// block takes the absolute difference to that channel's previous sample,
// pairs each of the low num_planes bits with the same plane of the channel's
// previous unpaired delta (10 gives a one, 01 a zero, equal pairs vanish) and
// packs the bits LSB first into a byte per channel. Every finished byte
// leaves on o_out with its channel; last marks the final byte that one
// sample caused. A sample flagged first_of_read, or the first one a channel
// sees after reset, only sets the reference. Sample beats go into an input
// register and are processed in one pass into a four-entry result queue, so
// a beat is accepted every cycle as long as the queue has room for a full
// pair. The output drains a single byte a cycle while o_out.ready is high,
// so samples that make two bytes can fill the queue and hold intake. A
// result passes the input register and then the queue before it shows on
// o_out. num_planes is written through i_cfg_we/i_cfg_wdata while the
// block is idle; values above MAX_PLANES act as MAX_PLANES, zero uses none.
// ----------------------------------------------------------------------------
module delta_von_neumann_debiaser_top #(
    parameter int NUM_CHANNELS = dvnd_pkg::NUM_CHANNELS_DEF,
    parameter int MAX_PLANES   = dvnd_pkg::MAX_PLANES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    dvnd_in_if.sink                    i_in,
    dvnd_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  logic [dvnd_pkg::CFG_W-1:0] i_cfg_wdata
);

    // configuration
    logic [dvnd_pkg::CFG_W-1:0] r_num_planes;

    // input register
    logic            r_in_vld;
    dvnd_pkg::t_item r_in;

    logic            in_ready;
    logic            proc;
    logic            room;
    logic            pop;
    dvnd_pkg::t_push push;
    dvnd_pkg::t_beat head;
    logic            head_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_planes <= dvnd_pkg::PLANES_RESET;
        end else if (i_cfg_we) begin
            r_num_planes <= i_cfg_wdata;
        end
    end

    // the held beat moves on whenever the queue can take a full pair
    assign proc     = r_in_vld & room;
    assign in_ready = ~r_in_vld | proc;
    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    // sample payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_in.channel       <= i_in.channel;
            r_in.sample        <= i_in.sample;
            r_in.first_of_read <= i_in.first_of_read;
        end
    end

    // delta, plane pairing and packing, channel state lives here
    dvnd_core #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .MAX_PLANES   (MAX_PLANES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (proc),
        .i_item       (r_in),
        .i_num_planes (r_num_planes),
        .o_push       (push)
    );

    // finished bytes wait here so a stalled sink never blocks intake at once
    dvnd_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_valid (head_vld),
        .o_room  (room)
    );

    assign pop               = head_vld & o_out.ready;
    assign o_out.valid       = head_vld;
    assign o_out.out_channel = head.out_channel;
    assign o_out.out_byte    = head.out_byte;
    assign o_out.last        = head.last;

endmodule

@@ src/dvnd_out_fifo.sv @@
// ----------------------------------------------------------------------------
// dvnd_out_fifo
// small result queue, two writes and one read per cycle
// ----------------------------------------------------------------------------
module dvnd_out_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dvnd_pkg::t_push i_push,
    input  logic            i_pop,
    output dvnd_pkg::t_beat o_head,
    output logic            o_valid,
    output logic            o_room
);

    localparam int PTR_W = $clog2(dvnd_pkg::OUT_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(dvnd_pkg::OUT_DEPTH - 2);

    dvnd_pkg::t_beat  r_mem [dvnd_pkg::OUT_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    logic             pop_ok;
    logic [CNT_W-1:0] n_push;
    logic [CNT_W-1:0] n_pop;
    logic [PTR_W-1:0] wp_next;

    assign pop_ok  = i_pop & o_valid;
    assign n_push  = CNT_W'(i_push.vld0) + CNT_W'(i_push.vld1);
    assign n_pop   = CNT_W'(pop_ok);
    assign wp_next = r_wp + PTR_W'(1);

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    // room for a full pair once this cycle's read is done
    assign o_room  = ((r_cnt - n_pop) <= ROOM_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PTR_W'(n_push);
            r_rp  <= r_rp + PTR_W'(n_pop);
            r_cnt <= r_cnt + n_push - n_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld0) begin
            r_mem[r_wp] <= i_push.beat0;
        end
        if (i_push.vld1) begin
            r_mem[wp_next] <= i_push.beat1;
        end
    end

endmodule

@@ src/dvnd_core.sv @@
// ----------------------------------------------------------------------------
// dvnd_core
// per-channel delta, plane pairing and byte packing in one pass
// ----------------------------------------------------------------------------
module dvnd_core #(
    parameter int NUM_CHANNELS = dvnd_pkg::NUM_CHANNELS_DEF,
    parameter int MAX_PLANES   = dvnd_pkg::MAX_PLANES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  dvnd_pkg::t_item            i_item,
    input  logic [dvnd_pkg::CFG_W-1:0] i_num_planes,
    output dvnd_pkg::t_push            o_push
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CH_W:0] NCH = (CH_W + 1)'(NUM_CHANNELS);

    logic [dvnd_pkg::SAMPLE_W-1:0] r_prev   [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]       r_pvalid;
    logic [MAX_PLANES-1:0]         r_pend_v [NUM_CHANNELS];
    logic [MAX_PLANES-1:0]         r_pend_b [NUM_CHANNELS];
    logic [2:0]                    r_bc     [NUM_CHANNELS];
    logic [dvnd_pkg::BYTE_W-1:0]   r_part   [NUM_CHANNELS];

    logic [CH_W-1:0]               idx;
    logic [CH_W:0]                 ch_ext;
    logic                          in_range;
    logic [dvnd_pkg::SAMPLE_W-1:0] cur;
    logic [dvnd_pkg::SAMPLE_W-1:0] prev;
    logic [dvnd_pkg::SAMPLE_W-1:0] delta;
    logic                          use_delta;

    logic [MAX_PLANES-1:0]         yield;
    logic [MAX_PLANES-1:0]         ybit;
    logic [MAX_PLANES-1:0]         n_pend_v;
    logic [MAX_PLANES-1:0]         n_pend_b;
    logic [15:0]                   y16;
    logic [4:0]                    rank     [MAX_PLANES];
    logic [4:0]                    n_yield;
    logic [4:0]                    tot;
    logic [4:0]                    pos;
    logic [dvnd_pkg::ACC_W-1:0]    acc;
    logic [1:0]                    n_bytes;
    logic [dvnd_pkg::BYTE_W-1:0]   n_part;

    assign idx      = CH_W'(i_item.channel);
    assign ch_ext   = (CH_W + 1)'(i_item.channel);
    assign in_range = (ch_ext < NCH);
    assign cur      = i_item.sample;
    assign prev     = r_prev[idx];

    assign use_delta = i_fire & in_range & ~i_item.first_of_read & r_pvalid[idx];

    // low 16 bits of the absolute difference
    assign delta = ($signed(cur) >= $signed(prev)) ? (cur - prev) : (prev - cur);

    always_comb begin
        for (int j = 0; j < MAX_PLANES; j++) begin
            logic act;
            act         = use_delta & (i_num_planes > dvnd_pkg::CFG_W'(j));
            yield[j]    = act & r_pend_v[idx][j] & (r_pend_b[idx][j] != delta[j]);
            ybit[j]     = r_pend_b[idx][j];
            n_pend_v[j] = act ? ~r_pend_v[idx][j] : r_pend_v[idx][j];
            n_pend_b[j] = (act & ~r_pend_v[idx][j]) ? delta[j] : r_pend_b[idx][j];
        end
    end

    assign y16     = 16'(yield);
    assign n_yield = dvnd_pkg::popcnt16(y16);
    assign tot     = {2'b00, r_bc[idx]} + n_yield;
    assign n_bytes = tot[4:3];

    // rank of each yielded bit among this sample's yields
    always_comb begin
        for (int j = 0; j < MAX_PLANES; j++) begin
            logic [15:0] msk;
            msk     = (16'd1 << j) - 16'd1;
            rank[j] = dvnd_pkg::popcnt16(y16 & msk);
        end
    end

    // held byte plus new bits scattered above it
    always_comb begin
        acc = {16'b0, r_part[idx]};
        pos = '0;
        for (int j = 0; j < MAX_PLANES; j++) begin
            pos = {2'b00, r_bc[idx]} + rank[j];
            if (yield[j] && ybit[j]) begin
                acc[pos] = 1'b1;
            end
        end
    end

    always_comb begin
        case (n_bytes)
            2'd0:    n_part = acc[7:0];
            2'd1:    n_part = acc[15:8];
            default: n_part = acc[23:16];
        endcase
    end

    always_comb begin
        o_push                   = '0;
        o_push.vld0              = use_delta & (n_bytes != 2'd0);
        o_push.vld1              = use_delta & (n_bytes == 2'd2);
        o_push.beat0.out_channel = i_item.channel;
        o_push.beat0.out_byte    = acc[7:0];
        o_push.beat0.last        = (n_bytes == 2'd1);
        o_push.beat1.out_channel = i_item.channel;
        o_push.beat1.out_byte    = acc[15:8];
        o_push.beat1.last        = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_pend_v[c] <= '0;
                r_bc[c]     <= '0;
                r_part[c]   <= '0;
            end
        end else if (i_fire && in_range) begin
            r_pvalid[idx] <= 1'b1;
            if (use_delta) begin
                r_pend_v[idx] <= n_pend_v;
                r_bc[idx]     <= tot[2:0];
                r_part[idx]   <= n_part;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && in_range) begin
            r_prev[idx] <= cur;
        end
        if (use_delta) begin
            r_pend_b[idx] <= n_pend_b;
        end
    end

endmodule

@@ src/dvnd_checker.sv @@
// ----------------------------------------------------------------------------
// dvnd_port_checker
// port-level checks of the debiaser output stream
// ----------------------------------------------------------------------------
module dvnd_port_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_out_channel,
    input logic [dvnd_pkg::BYTE_W-1:0] i_out_byte,
    input logic                        i_out_last
);

`include "delta_von_neumann_debiaser_top_macros.svh"

    // stalled beat holds
    `DVND_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_out_channel) && $stable(i_out_last), "stalled output beat changed")

    // reset empties the result queue
    `DVND_ASSERT_RESET(a_rst_empty, i_clk, i_rst_n, !i_out_valid, "output valid after reset")

    // a non-last byte is followed at once by the closing byte of its channel
    `DVND_ASSERT_NEXT(a_pair_follow, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_last, i_out_valid && i_out_last && (i_out_channel == $past(i_out_channel)), "second byte of a pair missing")

endmodule

bind delta_von_neumann_debiaser_top dvnd_port_checker u_dvnd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_channel (o_out.out_channel),
    .i_out_byte    (o_out.out_byte),
    .i_out_last    (o_out.last)
);

@@ tb/sv/dvnd_checker.sv @@
// ----------------------------------------------------------------------------
// dvnd_checker
// watches the sample and byte channels, predicts each debiased byte from
// the accepted samples and compares it field by field with the byte seen
// ----------------------------------------------------------------------------
module dvnd_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    dvnd_in_if                         in_mon,
    dvnd_out_if                        out_mon,
    input  logic                       i_cfg_we,
    input  logic [dvnd_pkg::CFG_W-1:0] i_cfg_wdata,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import dvnd_pkg::*;

    localparam int NCH  = NUM_CHANNELS_DEF;
    localparam int MAXP = MAX_PLANES_DEF;

    logic [SAMPLE_W-1:0] ref_smp   [NCH];
    logic                have_ref  [NCH];
    logic                held_vld  [NCH][MAXP];
    logic                held_bit  [NCH][MAXP];
    logic [2:0]          fill      [NCH];
    logic [BYTE_W-1:0]   part_byte [NCH];
    logic [CFG_W-1:0]    planes_cfg;
    t_beat               due_bytes [$];
    int                  fails = 0;

    // von neumann pairing of each used delta plane, bytes packed lsb first
    task automatic debias_sample(input t_item it);
        int          ch;
        int          cur;
        int          old;
        int          diff;
        int          span;
        logic [15:0] delta;
        logic        nb;
        t_beat       made [$];
        t_beat       one;

        ch = it.channel;
        if (it.first_of_read || !have_ref[ch]) begin
            ref_smp[ch]  = it.sample;
            have_ref[ch] = 1'b1;
            return;
        end
        cur  = int'($signed(it.sample));
        old  = int'($signed(ref_smp[ch]));
        diff = cur - old;
        if (diff < 0) begin
            diff = -diff;
        end
        delta       = diff[15:0];
        ref_smp[ch] = it.sample;
        span        = (planes_cfg > MAXP) ? MAXP : int'(planes_cfg);

        for (int j = 0; j < span; j++) begin
            nb = delta[j];
            if (!held_vld[ch][j]) begin
                held_vld[ch][j] = 1'b1;
                held_bit[ch][j] = nb;
                continue;
            end
            held_vld[ch][j] = 1'b0;
            if (held_bit[ch][j] == nb) begin
                continue;
            end
            // 10 gives a one, 01 a zero
            if (held_bit[ch][j]) begin
                part_byte[ch][fill[ch]] = 1'b1;
            end
            fill[ch] = fill[ch] + 3'd1;
            if (fill[ch] == 3'd0) begin
                one.out_channel = 1'(ch);
                one.out_byte    = part_byte[ch];
                one.last        = 1'b0;
                made.push_back(one);
                part_byte[ch] = '0;
            end
        end

        if (made.size() > 0) begin
            made[made.size()-1].last = 1'b1;
        end
        foreach (made[k]) begin
            due_bytes.push_back(made[k]);
        end
    endtask

    task automatic check_byte(input t_beat got);
        t_beat want;

        if (due_bytes.size() == 0) begin
            $display("%0t: byte beat with none due: expected none, actual ch %0d byte %02h last %0b",
                     $time, got.out_channel, got.out_byte, got.last);
            fails++;
            return;
        end
        want = due_bytes.pop_front();
        if (got.out_channel !== want.out_channel) begin
            $display("%0t: out_channel expected %0d actual %0d",
                     $time, want.out_channel, got.out_channel);
            fails++;
        end
        if (got.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, want.out_byte, got.out_byte);
            fails++;
        end
        if (got.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_item it;
        t_beat got;

        if (!i_rst_n) begin
            planes_cfg = PLANES_RESET;
            for (int c = 0; c < NCH; c++) begin
                ref_smp[c]   = '0;
                have_ref[c]  = 1'b0;
                fill[c]      = '0;
                part_byte[c] = '0;
                for (int j = 0; j < MAXP; j++) begin
                    held_vld[c][j] = 1'b0;
                    held_bit[c][j] = 1'b0;
                end
            end
            due_bytes.delete();
        end else begin
            // a byte leaving now always stems from an older sample
            if (out_mon.valid && out_mon.ready) begin
                got.out_channel = out_mon.out_channel;
                got.out_byte    = out_mon.out_byte;
                got.last        = out_mon.last;
                check_byte(got);
            end
            if (i_cfg_we) begin
                planes_cfg = i_cfg_wdata;
            end
            if (in_mon.valid && in_mon.ready) begin
                it.channel       = in_mon.channel;
                it.sample        = in_mon.sample;
                it.first_of_read = in_mon.first_of_read;
                debias_sample(it);
            end
        end
        o_pending    <= due_bytes.size();
        o_fail_count <= fails;
    end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// drives samples and num_planes settings into the debiaser with random
// gaps on both channels; the checker predicts and compares every byte
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dvnd_pkg::*;

    localparam int DRAIN_CYCLES   = 8;     // covers the result delay through the input register and queue
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any accepted beat
    localparam int PHASE_ITEMS    = 155;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               fail_count;
    int               pending;

    // percent chance that a side starts an idle burst; zero gives clean runs
    int               idle_pct = 0;
    int               stall_left = 0;
    int               quiet_cycles = 0;
    int               items_sent = 0;
    logic [15:0]      sent_last [2] = '{16'h0, 16'h0};

    dvnd_in_if  smp_bus ();
    dvnd_out_if byte_bus ();

    delta_von_neumann_debiaser_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (smp_bus),
        .o_out       (byte_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    dvnd_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .in_mon       (smp_bus),
        .out_mon      (byte_bus),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // byte side back-pressure: random stall bursts
    always @(posedge clk) begin
        if (stall_left > 0) begin
            byte_bus.ready <= 1'b0;
            stall_left     <= stall_left - 1;
        end else if ($urandom_range(99) < idle_pct) begin
            byte_bus.ready <= 1'b0;
            stall_left     <= $urandom_range(6);
        end else begin
            byte_bus.ready <= 1'b1;
        end
    end

    // a hang shows as a long stretch with no beat on either channel
    always @(posedge clk) begin
        if ((smp_bus.valid && smp_bus.ready) || (byte_bus.valid && byte_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one sample beat, with an optional gap in front of it
    task automatic send_sample(input logic ch, input logic [15:0] smp, input logic fr);
        if ($urandom_range(99) < idle_pct) begin
            smp_bus.valid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge clk);
        end
        smp_bus.valid         <= 1'b1;
        smp_bus.channel       <= ch;
        smp_bus.sample        <= smp;
        smp_bus.first_of_read <= fr;
        sent_last[ch] = smp;
        items_sent++;
        do @(posedge clk); while (!smp_bus.ready);
    endtask

    // stop sending and wait until every predicted byte has left the block
    task automatic drain_bytes();
        smp_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // a sample that makes no byte may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_planes(input logic [CFG_W-1:0] v);
        drain_bytes();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // audio-like content: mostly small steps, some full swings and extremes
    function automatic logic [15:0] pick_sample(input logic ch);
        case ($urandom_range(9))
            0, 1, 2:    return 16'($urandom);
            3, 4, 5, 6: return sent_last[ch] + 16'($urandom_range(64)) - 16'd32;
            7: begin
                case ($urandom_range(3))
                    0:       return 16'h8000;
                    1:       return 16'h7fff;
                    2:       return 16'h0000;
                    default: return 16'hffff;
                endcase
            end
            8:       return sent_last[ch];
            default: return ~sent_last[ch];
        endcase
    endfunction

    // a read opens both channels with first_of_read, then runs mixed samples
    task automatic run_read(input int beats);
        logic first_ch;
        logic ch;
        logic fr;

        first_ch = 1'($urandom_range(1));
        send_sample(first_ch, 16'($urandom), 1'b1);
        send_sample(!first_ch, 16'($urandom), 1'b1);
        for (int k = 0; k < beats; k++) begin
            ch = 1'($urandom_range(1));
            fr = ($urandom_range(49) == 0);     // stray restart inside a read
            send_sample(ch, pick_sample(ch), fr);
        end
    endtask

    // broken traffic: random fields, first_of_read at random
    task automatic run_noise(input int beats);
        for (int k = 0; k < beats; k++) begin
            send_sample(1'($urandom_range(1)), 16'($urandom), 1'($urandom_range(1)));
        end
    endtask

    initial begin
        logic [CFG_W-1:0] phase_planes [10];
        int               target;

        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        smp_bus.valid         = 1'b0;
        smp_bus.channel       = 1'b0;
        smp_bus.sample        = '0;
        smp_bus.first_of_read = 1'b0;
        byte_bus.ready        = 1'b0;
        phase_planes = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd17,
                         5'($urandom_range(15, 2)), 5'd3, 5'd12, 5'd16};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, reset plane count of 16
        idle_pct = 20;
        // channel without a reference since reset only stores the sample
        send_sample(1'b0, 16'h0000, 1'b0);
        send_sample(1'b0, 16'h7fff, 1'b0);
        // full-scale swing gives the largest delta
        send_sample(1'b0, 16'h8000, 1'b0);
        send_sample(1'b0, 16'h8000, 1'b0);
        send_sample(1'b0, 16'h7fff, 1'b0);
        send_sample(1'b0, 16'hffff, 1'b0);
        send_sample(1'b1, 16'h8000, 1'b1);
        send_sample(1'b1, 16'h7fff, 1'b0);
        send_sample(1'b1, 16'h7fff, 1'b0);
        send_sample(1'b1, 16'h8000, 1'b0);
        send_sample(1'b1, 16'h8000, 1'b0);
        // a new read keeps the pending plane bits and the partial byte
        send_sample(1'b0, 16'h1234, 1'b1);
        send_sample(1'b0, 16'h5555, 1'b0);
        send_sample(1'b1, 16'h0001, 1'b1);
        send_sample(1'b1, 16'h0000, 1'b0);
        send_sample(1'b1, 16'h0001, 1'b0);
        // zero planes: samples are only stored
        write_planes(5'd0);
        send_sample(1'b0, 16'hffff, 1'b0);
        send_sample(1'b0, 16'h0000, 1'b0);
        // plane count above the maximum acts as the maximum
        write_planes(5'd31);
        send_sample(1'b1, 16'h7fff, 1'b0);
        send_sample(1'b1, 16'h8000, 1'b0);
        send_sample(1'b1, 16'h7fff, 1'b0);
        // single plane
        write_planes(5'd1);
        send_sample(1'b0, 16'h0001, 1'b0);
        send_sample(1'b0, 16'h0000, 1'b0);
        send_sample(1'b0, 16'h0001, 1'b0);

        // random phases, each under its own plane count; last one has no idling
        foreach (phase_planes[p]) begin
            write_planes(phase_planes[p]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if (p == 9) begin
                    idle_pct = 0;
                end else begin
                    case ($urandom_range(2))
                        0:       idle_pct = 0;
                        1:       idle_pct = 8;
                        default: idle_pct = 30;
                    endcase
                end
                if ($urandom_range(9) == 0) begin
                    run_noise($urandom_range(8, 1));
                end else begin
                    run_read($urandom_range(40, 4));
                end
            end
        end

        drain_bytes();
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
